// ----- rtl/bdlp_pkg.sv -----
// Package for the button debouncer: widths, reset values, register indexes and shared types.
package bdlp_pkg;

  // Fixed field widths
  localparam int unsigned TIME_W = 32;
  localparam int unsigned CFG_W  = 16;
  localparam int unsigned MASK_W = 5;
  localparam int unsigned APB_DW = 32;
  localparam int unsigned APB_AW = 3;

  // Default button count
  localparam int unsigned BUTTON_COUNT_DEF = 5;

  // Register reset values
  localparam logic [CFG_W-1:0] DEBOUNCE_RESET   = CFG_W'(50);
  localparam logic [CFG_W-1:0] LONG_PRESS_RESET = CFG_W'(1000);

  // Register indexes, decoded from paddr[2]
  typedef enum logic {
    REG_DEBOUNCE   = 1'b0,
    REG_LONG_PRESS = 1'b1
  } reg_idx_e;

  // What one lane reports for the current sample
  typedef struct packed {
    logic held;
    logic pressed;
    logic released;
    logic long_press;
  } lane_flags_t;

  // One result item
  typedef struct packed {
    logic [MASK_W-1:0] held_mask;
    logic [MASK_W-1:0] just_pressed_mask;
    logic [MASK_W-1:0] just_released_mask;
    logic [MASK_W-1:0] long_press_mask;
  } result_t;

endpackage

// ----- rtl/bdlp_if.sv -----
// Valid/ready channel interfaces for samples and results.
interface bdlp_in_if;
  import bdlp_pkg::*;
  logic              valid;
  logic              ready;
  logic [TIME_W-1:0] now_ms;
  logic [MASK_W-1:0] raw_levels;

  modport source (output valid, output now_ms, output raw_levels, input ready);
  modport sink   (input valid, input now_ms, input raw_levels, output ready);
endinterface

interface bdlp_out_if;
  import bdlp_pkg::*;
  logic              valid;
  logic              ready;
  logic [MASK_W-1:0] held_mask;
  logic [MASK_W-1:0] just_pressed_mask;
  logic [MASK_W-1:0] just_released_mask;
  logic [MASK_W-1:0] long_press_mask;

  modport source (output valid, output held_mask, output just_pressed_mask,
                  output just_released_mask, output long_press_mask, input ready);
  modport sink   (input valid, input held_mask, input just_pressed_mask,
                  input just_released_mask, input long_press_mask, output ready);
endinterface

// ----- rtl/bdlp_lane.sv -----
// One button lane: debounce state, press/release detection and long-press timing.
module bdlp_lane (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        accept_i,
  input  logic [bdlp_pkg::TIME_W-1:0] now_ms_i,
  input  logic                        raw_i,
  input  logic [bdlp_pkg::CFG_W-1:0]  debounce_ms_i,
  input  logic [bdlp_pkg::CFG_W-1:0]  long_press_ms_i,
  output bdlp_pkg::lane_flags_t       flags_o
);
  import bdlp_pkg::*;

  logic              stable_q, stable_d;
  logic              prev_q;
  logic [TIME_W-1:0] change_q, change_d;
  logic [TIME_W-1:0] press_q, press_d;

  logic              changed;
  logic [TIME_W-1:0] db_elapsed;
  logic [TIME_W-1:0] held_time;
  logic              take_level;

  // Debounce: a raw edge restarts the timer, so elapsed time is then zero
  always_comb begin
    changed    = (raw_i != prev_q);
    change_d   = changed ? now_ms_i : change_q;
    db_elapsed = now_ms_i - change_d;
    take_level = (db_elapsed > {{(TIME_W-CFG_W){1'b0}}, debounce_ms_i}) &&
                 (raw_i != stable_q);
    stable_d   = take_level ? raw_i : stable_q;
    press_d    = (take_level && !raw_i) ? now_ms_i : press_q;
    held_time  = now_ms_i - press_d;
  end

  // Flags for this sample
  always_comb begin
    flags_o.held       = !stable_d;
    flags_o.pressed    = take_level && !raw_i;
    flags_o.released   = take_level && raw_i;
    flags_o.long_press = !stable_d &&
                         (held_time > {{(TIME_W-CFG_W){1'b0}}, long_press_ms_i});
  end

  // State update on each accepted sample
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stable_q <= 1'b1;
      prev_q   <= 1'b1;
      change_q <= '0;
      press_q  <= '0;
    end else if (accept_i) begin
      stable_q <= stable_d;
      prev_q   <= raw_i;
      change_q <= change_d;
      press_q  <= press_d;
    end
  end

endmodule

// ----- rtl/bdlp_merge.sv -----
// Merges lane flags into result masks; output register plus skid entry.
module bdlp_merge #(
  parameter int unsigned BUTTON_COUNT = bdlp_pkg::BUTTON_COUNT_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  accept_i,
  input  bdlp_pkg::lane_flags_t lanes_i [BUTTON_COUNT],
  input  logic                  out_ready_i,
  output logic                  ready_o,
  output logic                  out_valid_o,
  output bdlp_pkg::result_t     result_o
);
  import bdlp_pkg::*;

  result_t merged;
  result_t out_q, out_d;
  result_t skid_q, skid_d;
  logic    out_valid_q, out_valid_d;
  logic    skid_valid_q, skid_valid_d;
  logic    take;

  // Pack visible lanes into masks; lanes past the mask width stay hidden
  always_comb begin
    merged = '0;
    for (int i = 0; i < MASK_W; i++) begin
      if (i < int'(BUTTON_COUNT)) begin
        merged.held_mask[i]          = lanes_i[i].held;
        merged.just_pressed_mask[i]  = lanes_i[i].pressed;
        merged.just_released_mask[i] = lanes_i[i].released;
        merged.long_press_mask[i]    = lanes_i[i].long_press;
      end
    end
  end

  // Two-entry output: the skid entry catches a transfer while the output stalls
  always_comb begin
    take         = out_valid_q && out_ready_i;
    out_d        = out_q;
    out_valid_d  = out_valid_q;
    skid_d       = skid_q;
    skid_valid_d = skid_valid_q;
    if (!out_valid_q || take) begin
      if (skid_valid_q) begin
        out_d        = skid_q;
        out_valid_d  = 1'b1;
        skid_d       = merged;
        skid_valid_d = accept_i;
      end else begin
        out_d        = merged;
        out_valid_d  = accept_i;
      end
    end else if (accept_i) begin
      skid_d       = merged;
      skid_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign ready_o     = !skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign result_o    = out_q;

endmodule

// ----- rtl/button_debounce_long_press.sv -----
// Top level of the button debouncer with press, release and long-press reporting.
//
// Usage: each sample transfer on in_i carries a millisecond timestamp (now_ms)
// and the raw active-low levels of the buttons (raw_levels). For every sample
// one result transfer appears on out_o with the held, just-pressed,
// just-released and long-press masks. One lane per button works on the sample
// in parallel; a merge stage packs the lane flags into the masks.
// The result is registered in the merge output register, or first in the skid entry.
// Throughput: one sample per cycle while in_i.ready is high; each lane updates
// its state in the cycle of the transfer with two 32-bit subtract-and-compare paths.
// Stall: a two-entry output (register plus skid) keeps taking samples while a
// result waits; in_i.ready drops only when both entries are full.
// Reset: all buttons read released, timers zero, debounce_ms = 50 and
// long_press_ms = 1000; no result is pending.
// Configuration: APB writes at address 0 (debounce_ms) and 4 (long_press_ms),
// decoded on paddr[2]; pready is always high; write only while idle.
module button_debounce_long_press #(
  parameter int unsigned BUTTON_COUNT = bdlp_pkg::BUTTON_COUNT_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  bdlp_in_if.sink                     in_i,
  bdlp_out_if.source                  out_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [bdlp_pkg::APB_AW-1:0] paddr,
  input  logic [bdlp_pkg::APB_DW-1:0] pwdata,
  output logic [bdlp_pkg::APB_DW-1:0] prdata,
  output logic                        pready
);
  import bdlp_pkg::*;

  logic [CFG_W-1:0] debounce_q;
  logic [CFG_W-1:0] long_press_q;
  logic             cfg_wr;
  reg_idx_e         reg_idx;
  logic             in_accept;
  logic             in_ready;
  lane_flags_t      lane_flags [BUTTON_COUNT];
  result_t          result;

  // Configuration registers
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign reg_idx = reg_idx_e'(paddr[2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q   <= DEBOUNCE_RESET;
      long_press_q <= LONG_PRESS_RESET;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_DEBOUNCE:   debounce_q   <= pwdata[CFG_W-1:0];
        REG_LONG_PRESS: long_press_q <= pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_DEBOUNCE:   prdata = {{(APB_DW-CFG_W){1'b0}}, debounce_q};
      REG_LONG_PRESS: prdata = {{(APB_DW-CFG_W){1'b0}}, long_press_q};
      default:        prdata = '0;
    endcase
  end

  // Sample transfer
  assign in_i.ready = in_ready;
  assign in_accept  = in_i.valid && in_ready;

  // One lane per button; buttons beyond the input width read pressed
  for (genvar g = 0; g < BUTTON_COUNT; g++) begin : g_lane
    logic raw;
    if (g < MASK_W) begin : g_in
      assign raw = in_i.raw_levels[g];
    end else begin : g_zero
      assign raw = 1'b0;
    end

    bdlp_lane u_lane (
      .clk_i           (clk_i),
      .rst_ni          (rst_ni),
      .accept_i        (in_accept),
      .now_ms_i        (in_i.now_ms),
      .raw_i           (raw),
      .debounce_ms_i   (debounce_q),
      .long_press_ms_i (long_press_q),
      .flags_o         (lane_flags[g])
    );
  end

  // Merge and output buffering
  bdlp_merge #(
    .BUTTON_COUNT (BUTTON_COUNT)
  ) u_merge (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (in_accept),
    .lanes_i     (lane_flags),
    .out_ready_i (out_o.ready),
    .ready_o     (in_ready),
    .out_valid_o (out_o.valid),
    .result_o    (result)
  );

  assign out_o.held_mask          = result.held_mask;
  assign out_o.just_pressed_mask  = result.just_pressed_mask;
  assign out_o.just_released_mask = result.just_released_mask;
  assign out_o.long_press_mask    = result.long_press_mask;

  // A full skid entry implies a pending output
  a_skid_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready |-> out_o.valid) else $error("skid full without output");

  // A button cannot be pressed and released on the same sample
  a_press_release_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> ((out_o.just_pressed_mask & out_o.just_released_mask) == '0))
    else $error("press and release on same button");

  // Press and long press only for held buttons; release only for released ones
  a_flags_vs_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (((out_o.just_pressed_mask | out_o.long_press_mask) &
                      ~out_o.held_mask) == '0) &&
                    ((out_o.just_released_mask & out_o.held_mask) == '0))
    else $error("masks disagree with held state");

  // A debounce write lands in its register
  a_cfg_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfg_wr && reg_idx == REG_DEBOUNCE) |=> (debounce_q == $past(pwdata[CFG_W-1:0])))
    else $error("debounce register write lost");

endmodule
